>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRPW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irpw assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IRPW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irpw assertion failed");

`endif

>>> hw/rtl/irpw_pkg.sv
`default_nettype none

package irpw_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 16;
  localparam int CODE_W     = 7;
  localparam int EDGE_W     = 8;

  localparam int COMMAND_BITS_DEFAULT = 7;

  localparam logic [TICK_W-1:0] TICK_MAX          = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX          = '1;
  localparam logic [TICK_W-1:0] FRAME_TIMEOUT_RST = TICK_W'(27500);
  localparam logic [TICK_W-1:0] LEADER_MIN_RST    = TICK_W'(192);
  localparam logic [TICK_W-1:0] LEADER_MAX_RST    = TICK_W'(320);
  localparam logic [TICK_W-1:0] BIT_THRESHOLD_RST = TICK_W'(100);
  localparam logic [CODE_W-1:0] GO_CODE_RST       = CODE_W'(1);
  localparam logic [CODE_W-1:0] STOP_CODE_RST     = CODE_W'(4);
  localparam logic [CODE_W-1:0] BACK_CODE_RST     = CODE_W'(7);

  // Register index, taken from paddr[4:2]. Index seven is unused.
  typedef enum logic [2:0] {
    REG_FRAME_TIMEOUT = 3'd0,
    REG_LEADER_MIN    = 3'd1,
    REG_LEADER_MAX    = 3'd2,
    REG_BIT_THRESHOLD = 3'd3,
    REG_GO_CODE       = 3'd4,
    REG_STOP_CODE     = 3'd5,
    REG_BACK_CODE     = 3'd6
  } irpw_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] frame_timeout;
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] bit_threshold;
    logic [CODE_W-1:0] go_code;
    logic [CODE_W-1:0] stop_code;
    logic [CODE_W-1:0] back_code;
  } irpw_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/irpw_regs.sv
`default_nettype none

// APB register file holding the decoder's timing windows and command codes.
module irpw_regs
  import irpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output irpw_cfg_t                  cfg
);

  irpw_cfg_t cfg_r;
  irpw_cfg_t cfg_nxt;
  irpw_reg_t reg_sel;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = irpw_reg_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_TIMEOUT: cfg_nxt.frame_timeout = cfg_pwdata[TICK_W-1:0];
        REG_LEADER_MIN:    cfg_nxt.leader_min    = cfg_pwdata[TICK_W-1:0];
        REG_LEADER_MAX:    cfg_nxt.leader_max    = cfg_pwdata[TICK_W-1:0];
        REG_BIT_THRESHOLD: cfg_nxt.bit_threshold = cfg_pwdata[TICK_W-1:0];
        REG_GO_CODE:       cfg_nxt.go_code       = cfg_pwdata[CODE_W-1:0];
        REG_STOP_CODE:     cfg_nxt.stop_code     = cfg_pwdata[CODE_W-1:0];
        REG_BACK_CODE:     cfg_nxt.back_code     = cfg_pwdata[CODE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_TIMEOUT: cfg_prdata = CFG_DATA_W'(cfg_r.frame_timeout);
      REG_LEADER_MIN:    cfg_prdata = CFG_DATA_W'(cfg_r.leader_min);
      REG_LEADER_MAX:    cfg_prdata = CFG_DATA_W'(cfg_r.leader_max);
      REG_BIT_THRESHOLD: cfg_prdata = CFG_DATA_W'(cfg_r.bit_threshold);
      REG_GO_CODE:       cfg_prdata = CFG_DATA_W'(cfg_r.go_code);
      REG_STOP_CODE:     cfg_prdata = CFG_DATA_W'(cfg_r.stop_code);
      REG_BACK_CODE:     cfg_prdata = CFG_DATA_W'(cfg_r.back_code);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_timeout <= FRAME_TIMEOUT_RST;
      cfg_r.leader_min    <= LEADER_MIN_RST;
      cfg_r.leader_max    <= LEADER_MAX_RST;
      cfg_r.bit_threshold <= BIT_THRESHOLD_RST;
      cfg_r.go_code       <= GO_CODE_RST;
      cfg_r.stop_code     <= STOP_CODE_RST;
      cfg_r.back_code     <= BACK_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ir_pulse_width_command_decoder_unit.sv
// Pulse-width IR command decoder. Each input beat carries one sampled receiver
// level for one timer tick; the block times how long each level lasts with a
// saturating 16-bit tick counter, treats a level change as an edge, checks the
// first pulse against the leader window and turns the duration ending at every
// even edge after that into a data bit (below bit_threshold reads as 0), keeping
// the first COMMAND_BITS bits LSB first. After more than frame_timeout ticks
// without an edge, a valid frame with an edge past its leader is finished: a command
// matching the go, stop or back code sets the motor and LED lines, and one result
// beat carries frame_done. Every input beat yields exactly one result beat. The
// block takes one beat per clock cycle and its result is registered in the
// output register in the next cycle; the rate is set by the single update of
// the frame state per beat, and the input is only held off while a result
// waits to be taken. Registers sit on the APB port at byte addresses 0x00 to
// 0x18 and should only be written while no result is outstanding.

`default_nettype none

`include "assert_macros.svh"

module ir_pulse_width_command_decoder_unit
  import irpw_pkg::*;
#(
  parameter int COMMAND_BITS = COMMAND_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel: one sampled level per beat.
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_ir_level,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_motor_a,
  output logic                       out_motor_b,
  output logic                       out_led_on,
  output logic                       out_frame_done,
  output logic      [CODE_W-1:0]     out_command_value,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // The command register is compared against the 7-bit codes at the wider of
  // the two widths, so both are zero-extended to CMP_W.
  localparam int CMD_W = COMMAND_BITS;
  localparam int IDX_W = $clog2(COMMAND_BITS + 1);
  localparam int CMP_W = (COMMAND_BITS > CODE_W) ? COMMAND_BITS : CODE_W;

  irpw_cfg_t cfg;

  // Frame state.
  logic              prev_level_r,  prev_level_nxt;
  logic              frame_valid_r, frame_valid_nxt;
  logic [EDGE_W-1:0] edge_count_r,  edge_count_nxt;
  logic [IDX_W-1:0]  bit_index_r,   bit_index_nxt;
  logic [CMD_W-1:0]  command_r,     command_nxt;
  logic [TICK_W-1:0] elapsed_r,     elapsed_nxt;
  logic              drive_a_r,     drive_a_nxt;
  logic              drive_b_r,     drive_b_nxt;
  logic              indicator_r,   indicator_nxt;

  // Result register.
  logic              out_valid_r,   out_valid_nxt;
  logic              motor_a_r;
  logic              motor_b_r;
  logic              led_on_r;
  logic              frame_done_r;
  logic [CODE_W-1:0] command_value_r;

  logic              in_fire;
  logic              level_edge;
  logic [TICK_W-1:0] elapsed_inc;
  logic              timed_out;
  logic              done_nxt;
  logic [CMP_W-1:0]  command_cmp;
  logic [CMP_W-1:0]  shown_ext;
  logic [CODE_W-1:0] shown_nxt;

  irpw_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The output register doubles as the only buffer: a new beat is taken
  // whenever the held result is being drained or there is none.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_motor_a       = motor_a_r;
  assign out_motor_b       = motor_b_r;
  assign out_led_on        = led_on_r;
  assign out_frame_done    = frame_done_r;
  assign out_command_value = command_value_r;

  assign level_edge  = in_ir_level != prev_level_r;
  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
  assign timed_out   = elapsed_inc > cfg.frame_timeout;
  assign command_cmp = CMP_W'(command_r);

  // One tick of the decoder. On an edge the duration just ended may be judged
  // as the leader or as a data bit; without an edge the idle time is
  // checked against the timeout, which finishes the frame.
  always_comb begin
    prev_level_nxt  = prev_level_r;
    frame_valid_nxt = frame_valid_r;
    edge_count_nxt  = edge_count_r;
    bit_index_nxt   = bit_index_r;
    command_nxt     = command_r;
    elapsed_nxt     = elapsed_inc;
    drive_a_nxt     = drive_a_r;
    drive_b_nxt     = drive_b_r;
    indicator_nxt   = indicator_r;
    done_nxt        = 1'b0;

    if (!level_edge) begin
      if (timed_out) begin
        if (edge_count_r > EDGE_W'(2) && frame_valid_r) begin
          done_nxt = 1'b1;
          // Go wins over stop, and stop over back, when codes coincide.
          if (command_cmp == CMP_W'(cfg.go_code)) begin
            drive_a_nxt   = 1'b1;
            drive_b_nxt   = 1'b0;
            indicator_nxt = 1'b1;
          end else if (command_cmp == CMP_W'(cfg.stop_code)) begin
            drive_a_nxt   = 1'b1;
            drive_b_nxt   = 1'b1;
            indicator_nxt = 1'b0;
          end else if (command_cmp == CMP_W'(cfg.back_code)) begin
            drive_a_nxt   = 1'b0;
            drive_b_nxt   = 1'b1;
            indicator_nxt = 1'b1;
          end
        end
        frame_valid_nxt = 1'b0;
        edge_count_nxt  = '0;
        bit_index_nxt   = '0;
        command_nxt     = '0;
      end
    end else begin
      if (edge_count_r != EDGE_MAX) begin
        edge_count_nxt = edge_count_r + EDGE_W'(1);
      end
      if (edge_count_nxt == EDGE_W'(2)) begin
        if (cfg.leader_min < elapsed_inc && elapsed_inc < cfg.leader_max) begin
          frame_valid_nxt = 1'b1;
        end
      end else if (edge_count_nxt > EDGE_W'(2) && frame_valid_r && !edge_count_nxt[0]) begin
        if (bit_index_r < IDX_W'(COMMAND_BITS)) begin
          if (elapsed_inc >= cfg.bit_threshold) begin
            command_nxt = command_r | (CMD_W'(1) << bit_index_r);
          end
          bit_index_nxt = bit_index_r + IDX_W'(1);
        end
      end
      prev_level_nxt = in_ir_level;
      elapsed_nxt    = '0;
    end

    // A finishing frame shows its command before the clear; an edge shows
    // the bits including the one just taken.
    shown_ext = level_edge ? CMP_W'(command_nxt) : command_cmp;
    shown_nxt = shown_ext[CODE_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b1;
      frame_valid_r <= 1'b0;
      edge_count_r  <= '0;
      bit_index_r   <= '0;
      command_r     <= '0;
      elapsed_r     <= '0;
      drive_a_r     <= 1'b0;
      drive_b_r     <= 1'b0;
      indicator_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        prev_level_r  <= prev_level_nxt;
        frame_valid_r <= frame_valid_nxt;
        edge_count_r  <= edge_count_nxt;
        bit_index_r   <= bit_index_nxt;
        command_r     <= command_nxt;
        elapsed_r     <= elapsed_nxt;
        drive_a_r     <= drive_a_nxt;
        drive_b_r     <= drive_b_nxt;
        indicator_r   <= indicator_nxt;
      end
    end
  end

  // Result payload carries no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      motor_a_r       <= drive_a_nxt;
      motor_b_r       <= drive_b_nxt;
      led_on_r        <= indicator_nxt;
      frame_done_r    <= done_nxt;
      command_value_r <= shown_nxt;
    end
  end

  // A finished frame leaves no frame state behind.
  `IRPW_ASSERT_NEXT(a_done_clears, in_fire && done_nxt, !frame_valid_r && edge_count_r == '0)
  // The bit index never runs past the kept command width.
  `IRPW_ASSERT_IMPL(a_idx_bound, 1'b1, bit_index_r <= IDX_W'(COMMAND_BITS))
  // A frame only becomes valid at the edge that ends its leader pulse.
  `IRPW_ASSERT_IMPL(a_valid_edges, frame_valid_r, edge_count_r >= EDGE_W'(2))
  // Every accepted beat leaves a result waiting in the output register.
  `IRPW_ASSERT_NEXT(a_fire_result, in_fire, out_valid_r)

endmodule

`default_nettype wire
